### src/direct_mapped_sector_cache_defines.svh
// Assertion macros for the sector cache. Synthesis sees empty bodies.
`ifndef DIRECT_MAPPED_SECTOR_CACHE_DEFINES_SVH
`define DIRECT_MAPPED_SECTOR_CACHE_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked every clock edge outside reset
`define DMSC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition in one cycle implies property in the next
`define DMSC_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define DMSC_ASSERT(label, clk, rst, prop, msg)
`define DMSC_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif
`endif

### src/dmsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dmsc_pkg;

   // field widths
   localparam int DEV_W    = 4;
   localparam int LBA_W    = 48;
   localparam int WIDX_W   = 6;
   localparam int WORD_W   = 64;
   localparam int STATUS_W = 2;
   localparam int CNT_W    = 32;

   // line hash: (lba * HASH_MULT + device) mod line count, 64-bit wrap
   localparam int              HASH_W    = 64;
   localparam logic [31:0]     HASH_MULT = 32'd2654435761;
   localparam int              MUL_A_W   = 24;
   localparam int              PROD_W    = MUL_A_W + 32;
   localparam int              MOD_BITS  = 4;
   localparam int              MOD_STEPS = HASH_W / MOD_BITS;
   localparam int              MOD_CNT_W = $clog2(MOD_STEPS);

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_HIT  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ERR  = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic clear;
      logic load;
      logic mul_lo;
      logic mul_hi;
      logic sum;
      logic mod_step;
      logic tag_rd;
      logic tag_chk;
      logic exec;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_done;
      logic mod_done;
      logic open_req;
   } stat_type;

endpackage

`default_nettype wire

### src/dmsc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dmsc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  dmsc_pkg::stat_type stat,
   output logic               busy,
   output dmsc_pkg::cmd_type  cmd
);
   import dmsc_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SUM,
      ST_MOD,
      ST_TAG_RD,
      ST_TAG_CHK,
      ST_WORD_RD,
      ST_EXEC
   } state_type;

   state_type state_ff;

   // sequencing: opening words hash and check the tag, others go straight to the word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         unique case (state_ff)
            ST_CLEAR:   if (stat.clear_done) state_ff <= ST_IDLE;
            ST_IDLE: begin
               if (start) state_ff <= stat.open_req ? ST_MUL_LO : ST_WORD_RD;
            end
            ST_MUL_LO:  state_ff <= ST_MUL_HI;
            ST_MUL_HI:  state_ff <= ST_SUM;
            ST_SUM:     state_ff <= ST_MOD;
            ST_MOD:     if (stat.mod_done) state_ff <= ST_TAG_RD;
            ST_TAG_RD:  state_ff <= ST_TAG_CHK;
            ST_TAG_CHK: state_ff <= ST_WORD_RD;
            ST_WORD_RD: state_ff <= ST_EXEC;
            ST_EXEC:    state_ff <= ST_IDLE;
            default:    state_ff <= ST_IDLE;
         endcase
      end
   end

   // command decode
   always_comb begin
      cmd  = '0;
      busy = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_CLEAR:   cmd.clear    = 1'b1;
         ST_IDLE:    cmd.load     = start;
         ST_MUL_LO:  cmd.mul_lo   = 1'b1;
         ST_MUL_HI:  cmd.mul_hi   = 1'b1;
         ST_SUM:     cmd.sum      = 1'b1;
         ST_MOD:     cmd.mod_step = 1'b1;
         ST_TAG_RD:  cmd.tag_rd   = 1'b1;
         ST_TAG_CHK: cmd.tag_chk  = 1'b1;
         ST_WORD_RD: cmd          = '0;
         ST_EXEC:    cmd.exec     = 1'b1;
         default:    cmd          = '0;
      endcase
   end

endmodule

`default_nettype wire

### src/dmsc_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "direct_mapped_sector_cache_defines.svh"

module dmsc_dpath #(
   parameter int LINE_COUNT   = 64,
   parameter int SECTOR_WORDS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  dmsc_pkg::cmd_type               cmd,
   output dmsc_pkg::stat_type              stat,
   input  logic                            req_action,
   input  logic [dmsc_pkg::DEV_W-1:0]      req_device_id,
   input  logic [dmsc_pkg::LBA_W-1:0]      req_lba,
   input  logic [dmsc_pkg::WIDX_W-1:0]     req_word_index,
   input  logic [dmsc_pkg::WORD_W-1:0]     req_word_data,
   input  logic                            req_device_ok,
   output logic                            rsp_strobe,
   output logic [dmsc_pkg::WORD_W-1:0]     rsp_word_out,
   output logic [dmsc_pkg::STATUS_W-1:0]   rsp_status,
   output logic                            rsp_last_word,
   output logic [dmsc_pkg::CNT_W-1:0]      rsp_hit_count,
   output logic [dmsc_pkg::CNT_W-1:0]      rsp_miss_count,
   output logic [dmsc_pkg::CNT_W-1:0]      rsp_write_count,
   output logic [dmsc_pkg::CNT_W-1:0]      rsp_eviction_count
);
   import dmsc_pkg::*;

   localparam int LINE_W      = $clog2(LINE_COUNT);
   localparam int POS_W       = (SECTOR_WORDS > 1) ? $clog2(SECTOR_WORDS) : 1;
   localparam int WORDS_DEPTH = LINE_COUNT * SECTOR_WORDS;
   localparam int ADDR_W      = $clog2(WORDS_DEPTH);

   localparam logic [LINE_W:0]   LINE_LIM    = (LINE_W + 1)'(LINE_COUNT);
   localparam logic [LINE_W-1:0] LINE_LAST   = LINE_W'(LINE_COUNT - 1);
   localparam logic [POS_W-1:0]  LAST_POS    = POS_W'(SECTOR_WORDS - 1);
   localparam logic [ADDR_W-1:0] SECTOR_SPAN = ADDR_W'(SECTOR_WORDS);
   localparam logic [CNT_W-1:0]  CNT_MAX     = '1;

   typedef enum logic [1:0] {MODE_IDLE, MODE_HIT, MODE_FILL, MODE_WRITE} mode_type;

   typedef struct packed {
      logic             valid;
      logic [DEV_W-1:0] dev;
      logic [LBA_W-1:0] sector;
   } tag_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   // storage
   tag_type           tag_mem  [LINE_COUNT];
   logic [WORD_W-1:0] word_mem [WORDS_DEPTH];

   // latched word
   logic              action_ff;
   logic [WORD_W-1:0] data_ff;
   logic              ok_ff;
   logic [DEV_W-1:0]  key_dev_ff;
   logic [LBA_W-1:0]  key_lba_ff;

   // hash and address
   logic [MUL_A_W-1:0]   mul_a;
   logic [PROD_W-1:0]    prod_in;
   logic [PROD_W-1:0]    prod_ff;
   logic [HASH_W-1:0]    hash_ff;
   logic [LINE_W-1:0]    line_ff;
   logic [LINE_W-1:0]    line_in;
   logic [LINE_W-1:0]    rem;
   logic [LINE_W:0]      trial;
   logic [MOD_CNT_W-1:0] mod_cnt_ff;
   logic [ADDR_W-1:0]    base_ff;
   logic [ADDR_W-1:0]    word_addr;

   // memory ports
   tag_type           tag_q_ff;
   logic              tag_we;
   logic [LINE_W-1:0] tag_waddr;
   tag_type           tag_wdata;
   logic [WORD_W-1:0] word_q_ff;
   logic              word_we;

   // access state
   mode_type          mode_ff;
   logic              failed_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [LINE_W-1:0] clr_cnt_ff;
   logic [CNT_W-1:0]  hit_cnt_ff;
   logic [CNT_W-1:0]  miss_cnt_ff;
   logic [CNT_W-1:0]  write_cnt_ff;
   logic [CNT_W-1:0]  evict_cnt_ff;

   // response
   logic                rsp_valid_ff;
   logic [WORD_W-1:0]   rsp_word_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_last_ff;

   // execute-step decode
   logic                tag_match;
   logic                is_last;
   logic                exec_active;
   logic                exec_store;
   logic                exec_fail;
   logic                exec_set_valid;
   logic [WORD_W-1:0]   exec_word;
   logic [STATUS_W-1:0] exec_status;

   // one shared 24x32 multiplier for the two halves of the lba
   assign mul_a   = cmd.mul_hi ? key_lba_ff[LBA_W-1:MUL_A_W] : key_lba_ff[MUL_A_W-1:0];
   assign prod_in = PROD_W'(mul_a) * PROD_W'(HASH_MULT);

   // remainder unit: four hash bits per cycle, msb first
   always_comb begin
      rem   = line_ff;
      trial = '0;
      for (int i = 0; i < MOD_BITS; i++) begin
         trial = {rem, hash_ff[HASH_W-1-i]};
         if (trial >= LINE_LIM) trial = trial - LINE_LIM;
         rem = trial[LINE_W-1:0];
      end
      line_in = rem;
   end

   assign word_addr = base_ff + ADDR_W'(pos_ff);

   assign stat.open_req   = (req_word_index == '0);
   assign stat.mod_done   = (mod_cnt_ff == MOD_CNT_W'(MOD_STEPS - 1));
   assign stat.clear_done = (clr_cnt_ff == LINE_LAST);

   // tag compare
   assign tag_match = tag_q_ff.valid && (tag_q_ff.dev == key_dev_ff) &&
                      (tag_q_ff.sector == key_lba_ff);

   // per-word outcome
   assign is_last     = (pos_ff == LAST_POS);
   assign exec_active = (mode_ff != MODE_IDLE);

   always_comb begin
      exec_store     = 1'b0;
      exec_fail      = 1'b0;
      exec_set_valid = 1'b0;
      exec_word      = '0;
      exec_status    = STATUS_ERR;
      priority if (!exec_active || failed_ff) begin
         exec_status = STATUS_ERR;
      end else if (mode_ff == MODE_HIT) begin
         exec_word   = word_q_ff;
         exec_status = STATUS_HIT;
      end else if (!ok_ff) begin
         // line is already invalid while a fill, or a write opened with the device ok, is open
         exec_fail   = 1'b1;
         exec_status = STATUS_ERR;
      end else begin
         exec_store     = 1'b1;
         exec_set_valid = is_last;
         exec_word      = (mode_ff == MODE_FILL) ? data_ff : '0;
         exec_status    = STATUS_DONE;
      end
   end

   // tag write port: clearing pass, allocate on open, validate on last word
   always_comb begin
      tag_we    = 1'b0;
      tag_waddr = line_ff;
      tag_wdata = '{valid: 1'b0, dev: key_dev_ff, sector: key_lba_ff};
      priority if (cmd.clear) begin
         tag_we    = 1'b1;
         tag_waddr = clr_cnt_ff;
         tag_wdata = '0;
      end else if (cmd.tag_chk) begin
         tag_we = action_ff ? ok_ff : !tag_match;
      end else if (cmd.exec && exec_set_valid) begin
         tag_we          = 1'b1;
         tag_wdata.valid = 1'b1;
      end else begin
         tag_we = 1'b0;
      end
   end

   assign word_we = cmd.exec && exec_store;

   // tag memory
   always_ff @(posedge clock) begin
      if (tag_we) tag_mem[tag_waddr] <= tag_wdata;
      tag_q_ff <= tag_mem[line_ff];
   end

   // sector word memory
   always_ff @(posedge clock) begin
      if (word_we) word_mem[word_addr] <= data_ff;
      word_q_ff <= word_mem[word_addr];
   end

   // input latch, hash and address datapath
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         data_ff   <= req_word_data;
         ok_ff     <= req_device_ok;
         if (req_word_index == '0) begin
            key_dev_ff <= req_device_id;
            key_lba_ff <= req_lba;
         end
      end
      if (cmd.mul_lo || cmd.mul_hi) prod_ff <= prod_in;
      if (cmd.mul_hi) hash_ff <= HASH_W'(prod_ff) + HASH_W'(key_dev_ff);
      if (cmd.sum) begin
         hash_ff    <= hash_ff + HASH_W'({prod_ff, {MUL_A_W{1'b0}}});
         line_ff    <= '0;
         mod_cnt_ff <= '0;
      end
      if (cmd.mod_step) begin
         line_ff    <= line_in;
         hash_ff    <= hash_ff << MOD_BITS;
         mod_cnt_ff <= mod_cnt_ff + 1'b1;
      end
      if (cmd.tag_rd) base_ff <= ADDR_W'(line_ff) * SECTOR_SPAN;
   end

   // access state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         failed_ff    <= 1'b0;
         pos_ff       <= '0;
         clr_cnt_ff   <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         write_cnt_ff <= '0;
         evict_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.exec;
         if (cmd.clear) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (cmd.tag_chk) begin
            pos_ff    <= '0;
            failed_ff <= 1'b0;
            if (!action_ff) begin
               if (tag_match) begin
                  hit_cnt_ff <= sat_inc(hit_cnt_ff);
                  mode_ff    <= MODE_HIT;
               end else begin
                  miss_cnt_ff <= sat_inc(miss_cnt_ff);
                  if (tag_q_ff.valid) evict_cnt_ff <= sat_inc(evict_cnt_ff);
                  mode_ff <= MODE_FILL;
               end
            end else begin
               write_cnt_ff <= sat_inc(write_cnt_ff);
               mode_ff      <= MODE_WRITE;
               if (ok_ff && tag_q_ff.valid && !tag_match) begin
                  evict_cnt_ff <= sat_inc(evict_cnt_ff);
               end
            end
         end
         if (cmd.exec && exec_active) begin
            if (exec_fail) failed_ff <= 1'b1;
            if (is_last) begin
               mode_ff <= MODE_IDLE;
               pos_ff  <= '0;
            end else begin
               pos_ff <= pos_ff + 1'b1;
            end
         end
      end
   end

   // response registers
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_word_ff   <= exec_word;
         rsp_status_ff <= exec_status;
         rsp_last_ff   <= exec_active && is_last;
      end
   end

   assign rsp_strobe         = rsp_valid_ff;
   assign rsp_word_out       = rsp_word_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_last_word      = rsp_last_ff;
   assign rsp_hit_count      = hit_cnt_ff;
   assign rsp_miss_count     = miss_cnt_ff;
   assign rsp_write_count    = write_cnt_ff;
   assign rsp_eviction_count = evict_cnt_ff;

   `DMSC_ASSERT(a_pos_idle, clock, reset, (mode_ff == MODE_IDLE) |-> (pos_ff == '0), "word position not cleared while idle")
   `DMSC_ASSERT(a_hits_mono, clock, reset, !$past(reset) |-> (hit_cnt_ff >= $past(hit_cnt_ff)), "hit counter went backward")
   `DMSC_ASSERT(a_cmd_onehot, clock, reset, $onehot0(cmd), "more than one datapath command at once")
   `DMSC_ASSERT_NEXT(a_open_mode, clock, reset, cmd.tag_chk, mode_ff != MODE_IDLE, "opening word left access idle")
   `DMSC_ASSERT(a_store_mode, clock, reset, word_we |-> (mode_ff == MODE_FILL || mode_ff == MODE_WRITE), "word store outside fill or write")

endmodule

`default_nettype wire

### src/direct_mapped_sector_cache.sv
`timescale 1ns / 1ps
`default_nettype none

// Direct-mapped write-through sector cache, one 64-bit sector word per command.
// A word is taken when start is high and busy is low. A word with index zero
// opens an access: it hashes (lba, device) to a line through a shared 24x32
// multiplier and a remainder unit that retires four bits a cycle, then checks
// the tag; busy stays high through the hash, tag check, word read and execute.
// Any other word continues the open access: one registered read of the word
// memory and one execute step. Each result shows on the rsp_ ports for one
// cycle, flagged by rsp_strobe, in the same cycle that busy drops; there is
// no way to hold it off, so the receiver must take it then. The four counter
// ports hold their values between results. After reset the tag store is
// cleared one line per cycle, with busy high.
module direct_mapped_sector_cache #(
   parameter int LINE_COUNT   = 64,
   parameter int SECTOR_WORDS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_action,
   input  logic [dmsc_pkg::DEV_W-1:0]      req_device_id,
   input  logic [dmsc_pkg::LBA_W-1:0]      req_lba,
   input  logic [dmsc_pkg::WIDX_W-1:0]     req_word_index,
   input  logic [dmsc_pkg::WORD_W-1:0]     req_word_data,
   input  logic                            req_device_ok,
   output logic                            rsp_strobe,
   output logic [dmsc_pkg::WORD_W-1:0]     rsp_word_out,
   output logic [dmsc_pkg::STATUS_W-1:0]   rsp_status,
   output logic                            rsp_last_word,
   output logic [dmsc_pkg::CNT_W-1:0]      rsp_hit_count,
   output logic [dmsc_pkg::CNT_W-1:0]      rsp_miss_count,
   output logic [dmsc_pkg::CNT_W-1:0]      rsp_write_count,
   output logic [dmsc_pkg::CNT_W-1:0]      rsp_eviction_count
);
   import dmsc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   dmsc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   // hash, tag and word storage, counters
   dmsc_dpath #(
      .LINE_COUNT   (LINE_COUNT),
      .SECTOR_WORDS (SECTOR_WORDS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_action         (req_action),
      .req_device_id      (req_device_id),
      .req_lba            (req_lba),
      .req_word_index     (req_word_index),
      .req_word_data      (req_word_data),
      .req_device_ok      (req_device_ok),
      .rsp_strobe         (rsp_strobe),
      .rsp_word_out       (rsp_word_out),
      .rsp_status         (rsp_status),
      .rsp_last_word      (rsp_last_word),
      .rsp_hit_count      (rsp_hit_count),
      .rsp_miss_count     (rsp_miss_count),
      .rsp_write_count    (rsp_write_count),
      .rsp_eviction_count (rsp_eviction_count)
   );

endmodule

`default_nettype wire
